// ===== src/jtok_pkg.sv =====
// ---------------------------------------------------------------------------
// JSON tokenizer package
// Shared types and constants of the JSON tokenizer: action codes, byte
// classes, the queue beat between front and back, table entries and results.
// ---------------------------------------------------------------------------
package jtok_pkg;

  // Field widths of the result beat and of one table entry.
  localparam int KIND_W  = 3;
  localparam int POSF_W  = 24;
  localparam int CHILD_W = 10;
  localparam int PAR_W   = 11;
  localparam int TOTAL_W = 11;
  localparam int TIDX_W  = 10;

  // Child counts stop here instead of wrapping.
  localparam logic [CHILD_W-1:0] CHILD_MAX = 10'd1023;

  // Token kinds.
  localparam logic [KIND_W-1:0] KIND_NONE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OBJECT = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ARRAY  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_STRING = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PRIM   = 3'd4;

  // Actions carried by an input beat.
  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_FEED   = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_READ   = 2'd3
  } act_t;

  // Byte classes as the lexer sees them.
  typedef enum logic [3:0] {
    CLS_OPEN_OBJ  = 4'd0,
    CLS_OPEN_ARR  = 4'd1,
    CLS_CLOSE_OBJ = 4'd2,
    CLS_CLOSE_ARR = 4'd3,
    CLS_QUOTE     = 4'd4,
    CLS_BSLASH    = 4'd5,
    CLS_SPACE     = 4'd6,
    CLS_COLON     = 4'd7,
    CLS_COMMA     = 4'd8,
    CLS_BAD       = 4'd9,
    CLS_PLAIN     = 4'd10
  } cls_t;

  // One classified beat waiting for the back end.
  typedef struct packed {
    act_t              action;
    cls_t              cls;
    logic [TIDX_W-1:0] token_index;
  } item_t;

  // One token table entry.
  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [POSF_W-1:0]  start_pos;
    logic signed [POSF_W-1:0]  end_pos;
    logic [CHILD_W-1:0]        child_count;
    logic signed [PAR_W-1:0]   parent_index;
  } tok_entry_t;

  // One result beat.
  typedef struct packed {
    logic                      status;
    logic [TOTAL_W-1:0]        token_total;
    logic [KIND_W-1:0]         kind;
    logic signed [POSF_W-1:0]  start_pos;
    logic signed [POSF_W-1:0]  end_pos;
    logic [CHILD_W-1:0]        child_count;
    logic signed [PAR_W-1:0]   parent_index;
  } result_t;

endpackage

// ===== src/jtok_fifo.sv =====
// ---------------------------------------------------------------------------
// JSON tokenizer beat queue
// A small first-in first-out queue of register slots with a count.
// ---------------------------------------------------------------------------
module jtok_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             is_full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             has_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign is_full  = (count_r == DEPTH_C);
  assign has_data = (count_r != '0);
  assign do_wr    = wr_en && !is_full;
  assign do_rd    = rd_en && has_data;
  assign rd_data  = slot_r[rd_ptr_r];

  // Pointer and count update, wrapping at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Slot storage carries no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== src/jtok_front.sv =====
// ---------------------------------------------------------------------------
// JSON tokenizer front end
// Accepts input beats, classifies the document byte and queues the result.
// ---------------------------------------------------------------------------
module jtok_front import jtok_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        in_action,
  input  logic [7:0]        in_data_byte,
  input  logic [TIDX_W-1:0] in_token_index,
  output item_t             q_item,
  output logic              q_valid,
  input  logic              q_pop
);

  // Maps one byte to the class the lexer acts on.
  function automatic cls_t classify(input logic [7:0] c);
    cls_t k;
    case (c)
      8'h7B:   k = CLS_OPEN_OBJ;
      8'h5B:   k = CLS_OPEN_ARR;
      8'h7D:   k = CLS_CLOSE_OBJ;
      8'h5D:   k = CLS_CLOSE_ARR;
      8'h22:   k = CLS_QUOTE;
      8'h5C:   k = CLS_BSLASH;
      8'h09, 8'h0A, 8'h0D, 8'h20: k = CLS_SPACE;
      8'h3A:   k = CLS_COLON;
      8'h2C:   k = CLS_COMMA;
      default: k = ((c < 8'd32) || (c > 8'd126)) ? CLS_BAD : CLS_PLAIN;
    endcase
    return k;
  endfunction

  item_t                 push_item;
  logic [$bits(item_t)-1:0] head_bits;

  // Build the classified beat.
  always_comb begin
    push_item.action      = act_t'(in_action);
    push_item.cls         = classify(in_data_byte);
    push_item.token_index = in_token_index;
  end

  jtok_fifo #(
    .WIDTH($bits(item_t)),
    .DEPTH(2)
  ) u_inq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (push_item),
    .is_full (full),
    .rd_en   (q_pop),
    .rd_data (head_bits),
    .has_data(q_valid)
  );

  assign q_item = item_t'(head_bits);

endmodule

// ===== src/jtok_back.sv =====
// ---------------------------------------------------------------------------
// JSON tokenizer back end
// Runs the lexer, keeps the token table and produces one result per beat.
// ---------------------------------------------------------------------------
module jtok_back import jtok_pkg::*; #(
  parameter int TOKEN_SLOTS = 1024,
  parameter int DOC_BYTES   = 4194304
) (
  input  logic    clk,
  input  logic    rst_n,
  input  item_t   q_item,
  input  logic    q_valid,
  output logic    q_pop,
  input  logic    oq_full,
  output logic    res_push,
  output result_t res_data
);

  localparam int IDX_W = (TOKEN_SLOTS > 1) ? $clog2(TOKEN_SLOTS) : 1;
  localparam int CNT_W = $clog2(TOKEN_SLOTS + 1);
  localparam int POS_W = $clog2(DOC_BYTES + 1);
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(TOKEN_SLOTS);
  localparam logic [POS_W-1:0] DOC_C   = POS_W'(DOC_BYTES);

  typedef enum logic [3:0] {
    ST_EXEC  = 4'b0001,
    ST_CLOSE = 4'b0010,
    ST_LOAD  = 4'b0100,
    ST_READ  = 4'b1000
  } state_t;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_STRING = 3'b010,
    MODE_PRIM   = 3'b100
  } mode_t;

  function automatic logic [CHILD_W-1:0] sat_inc(input logic [CHILD_W-1:0] c);
    return (c == CHILD_MAX) ? c : c + 1'b1;
  endfunction

  // Token table memory.
  tok_entry_t mem [TOKEN_SLOTS];
  tok_entry_t rd_data_r;
  logic       we, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  tok_entry_t wr_data;

  // Document state.
  state_t           state_r, state_nxt;
  mode_t            mode_r, mode_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] pend_r, pend_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic             esc_r, esc_nxt;
  logic             err_r, err_nxt;
  logic             fin_r, fin_nxt;
  logic             cur_valid_r, cur_valid_nxt;
  logic [IDX_W-1:0] cur_idx_r, cur_idx_nxt;

  // Cached copy of the innermost open container.
  logic [KIND_W-1:0]        cp_kind_r, cp_kind_nxt;
  logic signed [POSF_W-1:0] cp_start_r, cp_start_nxt;
  logic [CHILD_W-1:0]       cp_children_r, cp_children_nxt;
  logic                     cp_par_valid_r, cp_par_valid_nxt;
  logic [IDX_W-1:0]         cp_par_idx_r, cp_par_idx_nxt;

  // Leaf token request from the lexer.
  logic                     leaf;
  logic [KIND_W-1:0]        leaf_kind;
  logic signed [POSF_W-1:0] leaf_start, leaf_end;

  logic                     take, tbl_full, want_close;
  logic [KIND_W-1:0]        want_kind;
  logic signed [PAR_W-1:0]  cur_par, cp_par;
  logic                     read_hit;

  assign take     = (state_r == ST_EXEC) && q_valid && !oq_full;
  assign q_pop    = take;
  assign tbl_full = (used_r == SLOTS_C);
  assign cur_par  = cur_valid_r ? PAR_W'(cur_idx_r) : '1;
  assign cp_par   = cp_par_valid_r ? PAR_W'(cp_par_idx_r) : '1;
  assign read_hit = 32'(q_item.token_index) < 32'(used_r);

  always_comb begin
    state_nxt        = state_r;
    mode_nxt         = mode_r;
    pos_nxt          = pos_r;
    pend_nxt         = pend_r;
    used_nxt         = used_r;
    esc_nxt          = esc_r;
    err_nxt          = err_r;
    fin_nxt          = fin_r;
    cur_valid_nxt    = cur_valid_r;
    cur_idx_nxt      = cur_idx_r;
    cp_kind_nxt      = cp_kind_r;
    cp_start_nxt     = cp_start_r;
    cp_children_nxt  = cp_children_r;
    cp_par_valid_nxt = cp_par_valid_r;
    cp_par_idx_nxt   = cp_par_idx_r;
    we               = 1'b0;
    wr_addr          = cur_idx_r;
    wr_data          = '0;
    rd_en            = 1'b0;
    rd_addr          = cp_par_idx_r;
    leaf             = 1'b0;
    leaf_kind        = KIND_PRIM;
    leaf_start       = '0;
    leaf_end         = '0;
    want_close       = 1'b0;
    want_kind        = (q_item.cls == CLS_CLOSE_OBJ) ? KIND_OBJECT : KIND_ARRAY;
    res_push         = 1'b0;
    res_data         = '0;

    case (state_r)
      ST_EXEC: begin
        if (take) begin
          case (q_item.action)
            ACT_START: begin
              pos_nxt       = '0;
              used_nxt      = '0;
              cur_valid_nxt = 1'b0;
              mode_nxt      = MODE_IDLE;
              esc_nxt       = 1'b0;
              pend_nxt      = '0;
              err_nxt       = 1'b0;
              fin_nxt       = 1'b0;
            end
            ACT_FINISH: begin
              if (!err_r && !fin_r) begin
                fin_nxt = 1'b1;
                if (mode_r == MODE_PRIM) begin
                  if (tbl_full) begin
                    err_nxt = 1'b1;
                  end else begin
                    leaf       = 1'b1;
                    leaf_kind  = KIND_PRIM;
                    leaf_start = POSF_W'(pend_r);
                    leaf_end   = POSF_W'(pos_r);
                    mode_nxt   = MODE_IDLE;
                    if (cur_valid_r) begin
                      err_nxt = 1'b1;
                    end
                  end
                end else if (mode_r == MODE_STRING || cur_valid_r) begin
                  err_nxt = 1'b1;
                end
              end
            end
            ACT_FEED: begin
              if (!err_r && !fin_r) begin
                if (pos_r >= DOC_C) begin
                  err_nxt = 1'b1;
                end else begin
                  pos_nxt = pos_r + 1'b1;
                  case (mode_r)
                    MODE_STRING: begin
                      if (esc_r) begin
                        esc_nxt = 1'b0;
                      end else if (q_item.cls == CLS_QUOTE) begin
                        if (tbl_full) begin
                          err_nxt = 1'b1;
                        end else begin
                          leaf       = 1'b1;
                          leaf_kind  = KIND_STRING;
                          leaf_start = POSF_W'(pend_r) + POSF_W'(1);
                          leaf_end   = POSF_W'(pos_r);
                          mode_nxt   = MODE_IDLE;
                        end
                      end else if (q_item.cls == CLS_BSLASH) begin
                        esc_nxt = 1'b1;
                      end
                    end
                    MODE_PRIM: begin
                      if (q_item.cls == CLS_COMMA || q_item.cls == CLS_SPACE ||
                          q_item.cls == CLS_CLOSE_OBJ || q_item.cls == CLS_CLOSE_ARR) begin
                        if (tbl_full) begin
                          err_nxt = 1'b1;
                        end else begin
                          leaf       = 1'b1;
                          leaf_kind  = KIND_PRIM;
                          leaf_start = POSF_W'(pend_r);
                          leaf_end   = POSF_W'(pos_r);
                          mode_nxt   = MODE_IDLE;
                          if (q_item.cls == CLS_CLOSE_OBJ ||
                              q_item.cls == CLS_CLOSE_ARR) begin
                            if (!cur_valid_r || cp_kind_r != want_kind) begin
                              err_nxt = 1'b1;
                            end else begin
                              want_close = 1'b1;
                            end
                          end
                        end
                      end else if (q_item.cls == CLS_BAD) begin
                        err_nxt = 1'b1;
                      end
                    end
                    default: begin
                      case (q_item.cls)
                        CLS_OPEN_OBJ, CLS_OPEN_ARR: begin
                          if (tbl_full) begin
                            err_nxt = 1'b1;
                          end else begin
                            // Park the old container in the table, cache the new one.
                            if (cur_valid_r) begin
                              we      = 1'b1;
                              wr_addr = cur_idx_r;
                              wr_data = '{cp_kind_r, cp_start_r, '1,
                                          sat_inc(cp_children_r), cp_par};
                            end
                            cp_kind_nxt      = (q_item.cls == CLS_OPEN_OBJ) ?
                                               KIND_OBJECT : KIND_ARRAY;
                            cp_start_nxt     = POSF_W'(pos_r);
                            cp_children_nxt  = '0;
                            cp_par_valid_nxt = cur_valid_r;
                            cp_par_idx_nxt   = cur_idx_r;
                            cur_valid_nxt    = 1'b1;
                            cur_idx_nxt      = IDX_W'(used_r);
                            used_nxt         = used_r + 1'b1;
                          end
                        end
                        CLS_CLOSE_OBJ, CLS_CLOSE_ARR: begin
                          if (!cur_valid_r || cp_kind_r != want_kind) begin
                            err_nxt = 1'b1;
                          end else begin
                            want_close = 1'b1;
                          end
                        end
                        CLS_QUOTE: begin
                          mode_nxt = MODE_STRING;
                          esc_nxt  = 1'b0;
                          pend_nxt = pos_r;
                        end
                        CLS_SPACE, CLS_COLON, CLS_COMMA: begin
                        end
                        CLS_BAD: begin
                          err_nxt = 1'b1;
                        end
                        default: begin
                          mode_nxt = MODE_PRIM;
                          pend_nxt = pos_r;
                        end
                      endcase
                    end
                  endcase
                end
              end
            end
            default: begin
              // Table read: the open container answers from its cache, others from memory or as unset.
              if (read_hit && cur_valid_r &&
                  32'(q_item.token_index) == 32'(cur_idx_r)) begin
                res_data.kind         = cp_kind_r;
                res_data.start_pos    = cp_start_r;
                res_data.end_pos      = '1;
                res_data.child_count  = cp_children_r;
                res_data.parent_index = cp_par;
              end else if (read_hit) begin
                rd_en   = 1'b1;
                rd_addr = IDX_W'(q_item.token_index);
              end else begin
                res_data.start_pos    = '1;
                res_data.end_pos      = '1;
                res_data.parent_index = '1;
              end
            end
          endcase

          // Leaf token write and parent child count.
          if (leaf) begin
            we       = 1'b1;
            wr_addr  = IDX_W'(used_r);
            wr_data  = '{leaf_kind, leaf_start, leaf_end, '0, cur_par};
            used_nxt = used_r + 1'b1;
            if (cur_valid_r) begin
              cp_children_nxt = sat_inc(cp_children_r);
            end
          end

          if (want_close) begin
            state_nxt = ST_CLOSE;
          end else if (rd_en) begin
            state_nxt = ST_READ;
          end else begin
            res_push             = 1'b1;
            res_data.status      = err_nxt;
            res_data.token_total = TOTAL_W'(used_nxt);
          end
        end
      end
      ST_CLOSE: begin
        // Retire the container and fetch its parent into the cache.
        we            = 1'b1;
        wr_addr       = cur_idx_r;
        wr_data       = '{cp_kind_r, cp_start_r, POSF_W'(pos_r), cp_children_r, cp_par};
        cur_valid_nxt = cp_par_valid_r;
        cur_idx_nxt   = cp_par_idx_r;
        if (cp_par_valid_r) begin
          rd_en     = 1'b1;
          rd_addr   = cp_par_idx_r;
          state_nxt = ST_LOAD;
        end else begin
          res_push             = 1'b1;
          res_data.status      = err_r;
          res_data.token_total = TOTAL_W'(used_r);
          state_nxt            = ST_EXEC;
        end
      end
      ST_LOAD: begin
        cp_kind_nxt          = rd_data_r.kind;
        cp_start_nxt         = rd_data_r.start_pos;
        cp_children_nxt      = rd_data_r.child_count;
        cp_par_valid_nxt     = !rd_data_r.parent_index[PAR_W-1];
        cp_par_idx_nxt       = IDX_W'(rd_data_r.parent_index);
        res_push             = 1'b1;
        res_data.status      = err_r;
        res_data.token_total = TOTAL_W'(used_r);
        state_nxt            = ST_EXEC;
      end
      ST_READ: begin
        res_push              = 1'b1;
        res_data.status       = err_r;
        res_data.token_total  = TOTAL_W'(used_r);
        res_data.kind         = rd_data_r.kind;
        res_data.start_pos    = rd_data_r.start_pos;
        res_data.end_pos      = rd_data_r.end_pos;
        res_data.child_count  = rd_data_r.child_count;
        res_data.parent_index = rd_data_r.parent_index;
        state_nxt             = ST_EXEC;
      end
      default: begin
        state_nxt = ST_EXEC;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_EXEC;
      mode_r      <= MODE_IDLE;
      pos_r       <= '0;
      pend_r      <= '0;
      used_r      <= '0;
      esc_r       <= 1'b0;
      err_r       <= 1'b0;
      fin_r       <= 1'b0;
      cur_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      pos_r       <= pos_nxt;
      pend_r      <= pend_nxt;
      used_r      <= used_nxt;
      esc_r       <= esc_nxt;
      err_r       <= err_nxt;
      fin_r       <= fin_nxt;
      cur_valid_r <= cur_valid_nxt;
    end
  end

  // Payload of the container cache.
  always_ff @(posedge clk) begin
    cur_idx_r      <= cur_idx_nxt;
    cp_kind_r      <= cp_kind_nxt;
    cp_start_r     <= cp_start_nxt;
    cp_children_r  <= cp_children_nxt;
    cp_par_valid_r <= cp_par_valid_nxt;
    cp_par_idx_r   <= cp_par_idx_nxt;
  end

  // Token table: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // The allocation count never passes the table size.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= SLOTS_C)
    else $error("token count beyond table size");

  // The open container is always an allocated token.
  a_cur_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (CNT_W'(cur_idx_r) < used_r))
    else $error("open container not allocated");

  // No new beat is taken while a close or read is still in progress.
  a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_EXEC) |-> !q_pop)
    else $error("beat taken while busy");

  // A close is always followed by an emitted result or a parent load.
  a_close_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLOSE) |-> (res_push || state_nxt == ST_LOAD))
    else $error("close step lost its result");

  // Load and read steps never write the table.
  a_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD || state_r == ST_READ) |-> !we)
    else $error("table written during a fetch step");

endmodule

// ===== src/json_tokenizer.sv =====
// ---------------------------------------------------------------------------
// JSON tokenizer
// Streaming non-strict JSON tokenizer that builds a token table.
// ---------------------------------------------------------------------------
// Usage: each input beat carries an action (start, feed byte, finish, read
// token entry), the document byte and a token index. A beat is taken when
// push is high and full is low; the front end classifies the byte and queues
// it in a two-entry queue for the back end. Every input beat gives exactly one
// result beat, waiting in a two-entry output queue: it is shown while empty is
// low and is taken when pop is high.
// Throughput: one beat per cycle for most bytes while the output queue has
// room; a closing bracket goes through a close step to retire the container
// and a load step when it has a parent to fetch from the table, and a table
// read goes through a read step for the registered memory read; no new beat
// is taken during these steps. A result passes the input queue and the back
// end before it is registered in the output queue and shown on the outputs.
// When the result side stalls, the output queue fills, the back end waits and
// then full rises; nothing is dropped. Reset clears the control state; the
// table itself is not cleared and entries beyond the token count read as unset.
// ---------------------------------------------------------------------------
module json_tokenizer import jtok_pkg::*; #(
  parameter int TOKEN_SLOTS = 1024,
  parameter int DOC_BYTES   = 4194304
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                in_action,
  input  logic [7:0]                in_data_byte,
  input  logic [TIDX_W-1:0]         in_token_index,
  output logic                      empty,
  input  logic                      pop,
  output logic                      out_status,
  output logic [TOTAL_W-1:0]        out_token_total,
  output logic [KIND_W-1:0]         out_kind,
  output logic signed [POSF_W-1:0]  out_start_pos,
  output logic signed [POSF_W-1:0]  out_end_pos,
  output logic [CHILD_W-1:0]        out_child_count,
  output logic signed [PAR_W-1:0]   out_parent_index
);

  item_t   q_item;
  logic    q_valid, q_pop;
  logic    oq_full, oq_valid, res_push;
  result_t res_data, res_head;
  logic [$bits(result_t)-1:0] head_bits;

  // Front end: accept and classify.
  jtok_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_action     (in_action),
    .in_data_byte  (in_data_byte),
    .in_token_index(in_token_index),
    .q_item        (q_item),
    .q_valid       (q_valid),
    .q_pop         (q_pop)
  );

  // Back end: lexer and token table.
  jtok_back #(
    .TOKEN_SLOTS(TOKEN_SLOTS),
    .DOC_BYTES  (DOC_BYTES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .oq_full (oq_full),
    .res_push(res_push),
    .res_data(res_data)
  );

  // Result queue.
  jtok_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(2)
  ) u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_data),
    .is_full (oq_full),
    .rd_en   (pop),
    .rd_data (head_bits),
    .has_data(oq_valid)
  );

  assign res_head         = result_t'(head_bits);
  assign empty            = !oq_valid;
  assign out_status       = res_head.status;
  assign out_token_total  = res_head.token_total;
  assign out_kind         = res_head.kind;
  assign out_start_pos    = res_head.start_pos;
  assign out_end_pos      = res_head.end_pos;
  assign out_child_count  = res_head.child_count;
  assign out_parent_index = res_head.parent_index;

endmodule

// ===== dv/json_tokenizer_checker.sv =====
// ---------------------------------------------------------------------------
// JSON tokenizer checker
// Watches both queue channels of the tokenizer, predicts each result beat
// from the accepted input beats and compares it field by field.
// ---------------------------------------------------------------------------
module json_tokenizer_checker import jtok_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  logic                      full,
  input  logic [1:0]                in_action,
  input  logic [7:0]                in_data_byte,
  input  logic [TIDX_W-1:0]         in_token_index,
  input  logic                      empty,
  input  logic                      pop,
  input  logic                      out_status,
  input  logic [TOTAL_W-1:0]        out_token_total,
  input  logic [KIND_W-1:0]         out_kind,
  input  logic signed [POSF_W-1:0]  out_start_pos,
  input  logic signed [POSF_W-1:0]  out_end_pos,
  input  logic [CHILD_W-1:0]        out_child_count,
  input  logic signed [PAR_W-1:0]   out_parent_index,
  output int                        fail_count,
  output int                        pending,
  output int                        beats_in,
  output int                        beats_out
);

  localparam int SLOTS     = 1024;
  localparam int DOC_LIMIT = 4194304;

  typedef enum int {LEX_IDLE, LEX_STRING, LEX_PRIM} lex_t;

  // Shadow token table and lexer state.
  int   tab_kind [SLOTS];
  int   tab_start[SLOTS];
  int   tab_end  [SLOTS];
  int   tab_child[SLOTS];
  int   tab_par  [SLOTS];
  int   doc_pos, tok_used, open_parent, pend_start;
  lex_t lex;
  bit   in_escape, sticky_err, doc_done;

  result_t expected_q[$];

  function automatic void clear_doc();
    doc_pos = 0; tok_used = 0; open_parent = -1; lex = LEX_IDLE;
    in_escape = 0; pend_start = 0; sticky_err = 0; doc_done = 0;
  endfunction

  // Allocates an entry under the open container; -1 on table overflow.
  function automatic int alloc_token(int k, int s, int e);
    if (tok_used >= SLOTS) begin
      sticky_err = 1;
      return -1;
    end
    tab_kind[tok_used] = k;
    tab_start[tok_used] = s;
    tab_end[tok_used] = e;
    tab_child[tok_used] = 0;
    tab_par[tok_used] = open_parent;
    tok_used++;
    if (open_parent >= 0 && tab_child[open_parent] < int'(CHILD_MAX))
      tab_child[open_parent]++;
    return tok_used - 1;
  endfunction

  function automatic bit is_gap(logic [7:0] c);
    return c == 8'h09 || c == 8'h0D || c == 8'h0A || c == 8'h20;
  endfunction

  // Byte seen between tokens.
  function automatic void between_tokens(logic [7:0] c, int p);
    int idx;
    int want;
    if (c == "{" || c == "[") begin
      idx = alloc_token(int'(c == "{" ? KIND_OBJECT : KIND_ARRAY), p, -1);
      if (idx >= 0) open_parent = idx;
    end else if (c == "}" || c == "]") begin
      want = int'((c == "}") ? KIND_OBJECT : KIND_ARRAY);
      if (open_parent < 0 || tab_kind[open_parent] != want) begin
        sticky_err = 1;
        return;
      end
      tab_end[open_parent] = p + 1;
      open_parent = tab_par[open_parent];
    end else if (c == "\"") begin
      lex = LEX_STRING;
      in_escape = 0;
      pend_start = p;
    end else if (is_gap(c) || c == ":" || c == ",") begin
    end else if (c < 8'd32 || c > 8'd126) begin
      sticky_err = 1;
    end else begin
      lex = LEX_PRIM;
      pend_start = p;
    end
  endfunction

  function automatic void feed_byte(logic [7:0] c);
    int p;
    p = doc_pos;
    if (p >= DOC_LIMIT) begin
      sticky_err = 1;
      return;
    end
    doc_pos = p + 1;
    if (lex == LEX_STRING) begin
      if (in_escape) in_escape = 0;
      else if (c == "\"") begin
        if (alloc_token(int'(KIND_STRING), pend_start + 1, p) >= 0) lex = LEX_IDLE;
      end else if (c == "\\") in_escape = 1;
    end else if (lex == LEX_PRIM) begin
      if (c == "," || c == "]" || c == "}" || is_gap(c)) begin
        if (alloc_token(int'(KIND_PRIM), pend_start, p) < 0) return;
        lex = LEX_IDLE;
        between_tokens(c, p);
      end else if (c < 8'd32 || c > 8'd126) sticky_err = 1;
    end else begin
      between_tokens(c, p);
    end
  endfunction

  function automatic void finish_doc();
    doc_done = 1;
    if (lex == LEX_PRIM) begin
      if (alloc_token(int'(KIND_PRIM), pend_start, doc_pos) < 0) return;
      lex = LEX_IDLE;
    end
    if (lex == LEX_STRING || open_parent != -1) sticky_err = 1;
  endfunction

  // Applies one input beat and returns the result beat it causes.
  function automatic result_t predict_result(act_t a, logic [7:0] c, logic [9:0] idx);
    result_t r;
    r = '0;
    case (a)
      ACT_START: clear_doc();
      ACT_FEED: if (!sticky_err && !doc_done) feed_byte(c);
      ACT_FINISH: if (!sticky_err && !doc_done) finish_doc();
      default: begin
        if (int'(idx) < tok_used) begin
          r.kind = KIND_W'(tab_kind[idx]);
          r.start_pos = POSF_W'(tab_start[idx]);
          r.end_pos = POSF_W'(tab_end[idx]);
          r.child_count = CHILD_W'(tab_child[idx]);
          r.parent_index = PAR_W'(tab_par[idx]);
        end else begin
          r.start_pos = '1;
          r.end_pos = '1;
          r.parent_index = '1;
        end
      end
    endcase
    r.status = sticky_err;
    r.token_total = TOTAL_W'(tok_used);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Result beats are compared first; an input beat cannot answer in the same cycle.
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      clear_doc();
      expected_q.delete();
    end else begin
      if (pop && !empty) begin
        beats_out++;
        if (expected_q.size() == 0) begin
          $display("%0t: result beat with no expectation, actual status %0h total %0h",
                   $time, out_status, out_token_total);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("token_total", 32'(want.token_total), 32'(out_token_total));
          check_field("kind", 32'(want.kind), 32'(out_kind));
          check_field("start_pos", 32'(want.start_pos), 32'(out_start_pos));
          check_field("end_pos", 32'(want.end_pos), 32'(out_end_pos));
          check_field("child_count", 32'(want.child_count), 32'(out_child_count));
          check_field("parent_index", 32'(want.parent_index), 32'(out_parent_index));
        end
      end
      if (push && !full) begin
        beats_in++;
        expected_q.push_back(predict_result(act_t'(in_action), in_data_byte, in_token_index));
      end
    end
    pending <= expected_q.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
    beats_in = 0;
    beats_out = 0;
  end

endmodule

// ===== dv/tb.sv =====
// ---------------------------------------------------------------------------
// JSON tokenizer testbench
// Drives directed and random documents through the tokenizer with random
// gaps on both queues; the checker predicts and compares every result beat.
// ---------------------------------------------------------------------------
module tb;
  import jtok_pkg::*;

  logic                      clk = 0;
  logic                      rst_n = 0;
  logic                      push = 0;
  logic                      full;
  logic [1:0]                in_action = ACT_START;
  logic [7:0]                in_data_byte = '0;
  logic [TIDX_W-1:0]         in_token_index = '0;
  logic                      empty;
  logic                      pop = 0;
  logic                      out_status;
  logic [TOTAL_W-1:0]        out_token_total;
  logic [KIND_W-1:0]         out_kind;
  logic signed [POSF_W-1:0]  out_start_pos;
  logic signed [POSF_W-1:0]  out_end_pos;
  logic [CHILD_W-1:0]        out_child_count;
  logic signed [PAR_W-1:0]   out_parent_index;
  int                        fail_count, pending, beats_in, beats_out;
  int                        tx_idle = 27;
  int                        rx_idle = 65;
  int                        junk_rate = 0;
  int                        docs = 0;

  json_tokenizer dut (.*);
  json_tokenizer_checker chk (.*);

  always #5 clk = ~clk;

  // Result side stalls at random.
  always @(negedge clk) pop <= rst_n && ($urandom_range(99) >= rx_idle);

  // One input beat; returns on the falling edge after it was taken.
  task automatic put(act_t a, logic [7:0] b, logic [9:0] i);
    while ($urandom_range(99) < tx_idle) begin
      push = 0;
      @(negedge clk);
    end
    push = 1;
    in_action = a;
    in_data_byte = b;
    in_token_index = i;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic feed(logic [7:0] b);
    if (junk_rate > 0 && $urandom_range(99) < junk_rate)
      put(ACT_FEED, 8'($urandom_range(255)), 10'($urandom));
    put(ACT_FEED, b, 10'($urandom));
  endtask

  task automatic new_doc();
    put(ACT_START, 8'($urandom), 10'($urandom));
    docs++;
  endtask

  task automatic reads(int n, int span);
    repeat (n) put(ACT_READ, 8'($urandom), 10'($urandom_range(span)));
  endtask

  task automatic maybe_space();
    case ($urandom_range(7))
      0: feed(" ");
      1: feed(8'h0A);
      2: feed(8'h09);
      3: feed(8'h0D);
      default: ;
    endcase
  endtask

  // A string with random content, escapes included.
  task automatic emit_string();
    feed("\"");
    repeat ($urandom_range(3)) begin
      if ($urandom_range(4) == 0) begin
        feed("\\");
        feed($urandom_range(3) == 0 ? 8'h22 : 8'($urandom_range(255)));
      end else begin
        feed($urandom_range(3) == 0 ? 8'($urandom_range(255)) :
             8'(8'h61 + $urandom_range(25)));
      end
    end
    feed("\"");
  endtask

  task automatic emit_prim();
    string chars;
    chars = "0123456789tfnul.-+e:\"x";
    repeat (1 + $urandom_range(2)) feed(chars[$urandom_range(chars.len() - 1)]);
  endtask

  // A mostly well-formed value; containers nest down to a small depth.
  task automatic emit_value(int depth);
    int n;
    int sel;
    sel = (depth > 2) ? $urandom_range(1) : $urandom_range(3);
    n = $urandom_range(3);
    case (sel)
      0: emit_string();
      1: emit_prim();
      2: begin
        feed("{");
        for (int k = 0; k < n; k++) begin
          maybe_space();
          emit_string();
          feed(":");
          emit_value(depth + 1);
          if (k < n - 1) feed(",");
        end
        maybe_space();
        feed("}");
      end
      default: begin
        feed("[");
        for (int k = 0; k < n; k++) begin
          maybe_space();
          emit_value(depth + 1);
          if (k < n - 1) feed(",");
        end
        feed("]");
      end
    endcase
  endtask

  task automatic drain();
    push = 0;
    while (pending != 0 || beats_in != beats_out) @(negedge clk);
  endtask

  // Random documents: mostly well-formed, some broken, some pure noise.
  task automatic random_docs(int beats);
    int target;
    int sel;
    target = beats_in + beats;
    while (beats_in < target) begin
      sel = $urandom_range(9);
      new_doc();
      junk_rate = (sel == 7) ? 8 : 0;
      if (sel < 8) begin
        maybe_space();
        emit_value(0);
        if ($urandom_range(5) == 0) put(ACT_FEED, 8'($urandom_range(255)), 10'($urandom));
      end else begin
        repeat ($urandom_range(12))
          put(act_t'($urandom_range(3)), 8'($urandom), 10'($urandom));
      end
      junk_rate = 0;
      if ($urandom_range(9) != 0) put(ACT_FINISH, 8'($urandom), 10'($urandom));
      repeat ($urandom_range(2)) put(ACT_FEED, 8'($urandom), 10'($urandom));
      reads(2 + $urandom_range(4), $urandom_range(3) == 0 ? 1023 : 24);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n = 1;

    // Directed: nested document with an escape, read back the first entry, the inner array and an unset index.
    new_doc();
    feed("{"); feed("\""); feed("a"); feed("\\"); feed("\""); feed("\"");
    feed(":"); feed("1"); feed(","); feed("["); feed("t"); feed("]"); feed("}");
    put(ACT_FINISH, 8'h00, 10'h000);
    put(ACT_FEED, 8'hFF, 10'h3FF);
    reads(1, 0); put(ACT_READ, 8'hFF, 10'd3); put(ACT_READ, 8'h00, 10'h3FF);
    // Stray closer, mismatched closer, bad byte in and outside a primitive, open string.
    new_doc(); feed("]");
    new_doc(); feed("["); feed("}"); put(ACT_READ, 8'h00, 10'd0);
    new_doc(); feed("a"); feed(8'h0B);
    new_doc(); feed(8'h7F);
    new_doc(); feed("\""); feed("x"); put(ACT_FINISH, 8'h00, 10'd0);
    // Primitive open at the finish is closed at the document length.
    new_doc(); feed("1"); feed("2"); put(ACT_FINISH, 8'h00, 10'd0);
    put(ACT_READ, 8'h00, 10'd0);

    // Sender holds off until every result is back.
    drain();

    random_docs(90);
    tx_idle = 65; rx_idle = 27;
    random_docs(90);

    // One deep nest of arrays: every outer level is parked and the table overflows.
    tx_idle = 0; rx_idle = 0;
    new_doc();
    repeat (1025) feed("[");
    put(ACT_FINISH, 8'h00, 10'd0);
    put(ACT_READ, 8'h00, 10'd0);
    put(ACT_READ, 8'h00, 10'd512);
    put(ACT_READ, 8'h00, 10'd1023);
    random_docs(90);

    push = 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("tb: %0d documents, %0d input beats and %0d result beats checked",
             docs, beats_in, beats_out);
    $display("tb: directed faults, random nested documents, noise and a table overflow");
    if (fail_count == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20000000;
    $display("tb: errors");
    $finish;
  end

endmodule
